>>> rtl/btsp_pkg.sv
// Shared types and constants of the bencode token stream parser.
package btsp_pkg;

  localparam int RES_MAX = 3;
  localparam int RIDX_W  = 2;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_E     = 8'h65;

  localparam logic [1:0] SEEN_MAX = 2'd3;

  typedef enum logic [1:0] {
    EV_BYTE = 2'd0,
    EV_END  = 2'd1,
    EV_EOI  = 2'd2
  } ev_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_TRUNC  = 2'd1,
    ST_UNTERM = 2'd2,
    ST_SAT    = 2'd3
  } status_t;

  localparam logic KIND_STR = 1'b0;
  localparam logic KIND_INT = 1'b1;

  typedef struct packed {
    ev_t        ev;
    logic [7:0] data;
    logic       kind;
    status_t    status;
  } res_t;

  // All results caused by one input byte, oldest in slot 0.
  typedef struct packed {
    logic [RIDX_W-1:0]     n;
    res_t [RES_MAX-1:0]    res;
  } bundle_t;

  function automatic res_t mk_res(ev_t ev, logic [7:0] data, logic kind, status_t status);
    res_t r;
    r.ev     = ev;
    r.data   = data;
    r.kind   = kind;
    r.status = status;
    return r;
  endfunction

endpackage

>>> rtl/btsp_front.sv
// Front end: parser state and per-byte classification into result bundles.
module btsp_front #(
  parameter int LEN_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         in_byte,
  input  logic               in_final_byte,
  output logic               q_push,
  output btsp_pkg::bundle_t  q_bundle
);
  import btsp_pkg::*;

  typedef enum logic [1:0] {
    MODE_START, MODE_SINGLE, MODE_SCAN, MODE_NONE
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_LEN, PH_LENTAIL, PH_DATA, PH_INT, PH_DONE
  } phase_t;

  mode_t               mode_r, mode_nxt;
  phase_t              phase_r, phase_nxt;
  logic [LEN_BITS-1:0] cnt_r, cnt_nxt, cnt_dec;
  logic [1:0]          seen_r, seen_nxt;
  logic                ovf_r, ovf_nxt;
  logic [LEN_BITS+3:0] len_ext, len_v;
  logic                is_digit;
  logic [3:0]          dval;
  logic [RIDX_W-1:0]   n_v;
  res_t [RES_MAX-1:0]  res_v;
  phase_t              done_phase;
  status_t             end_st;

  assign is_digit   = (in_byte >= CH_0) && (in_byte <= CH_9);
  assign dval       = in_byte[3:0];
  assign len_ext    = {4'b0, cnt_r};
  // length * 10 + digit as shift-add
  assign len_v      = (len_ext << 3) + (len_ext << 1) + {{LEN_BITS{1'b0}}, dval};
  assign cnt_dec    = cnt_r - {{(LEN_BITS-1){1'b0}}, 1'b1};
  assign done_phase = (mode_r == MODE_SCAN) ? PH_IDLE : PH_DONE;
  assign end_st     = ovf_r ? ST_SAT : ST_OK;

  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    seen_nxt  = (seen_r == SEEN_MAX) ? SEEN_MAX : seen_r + 2'd1;
    n_v       = '0;
    res_v     = '0;

    if (in_final_byte && (seen_r < 2'd2)) begin
      // short input: one empty string element
      res_v[n_v] = mk_res(EV_END, 8'h00, KIND_STR, ST_OK);
      n_v = n_v + 2'd1;
      res_v[n_v] = mk_res(EV_EOI, 8'h00, KIND_STR, ST_OK);
      n_v = n_v + 2'd1;
      mode_nxt  = MODE_START;
      phase_nxt = PH_IDLE;
      cnt_nxt   = '0;
      seen_nxt  = '0;
      ovf_nxt   = 1'b0;
    end else begin
      if (mode_r == MODE_START) begin
        if (is_digit) begin
          mode_nxt  = MODE_SINGLE;
          phase_nxt = PH_LEN;
          cnt_nxt   = {{(LEN_BITS-4){1'b0}}, dval};
          ovf_nxt   = 1'b0;
        end else if (in_byte == CH_I) begin
          mode_nxt  = MODE_SINGLE;
          phase_nxt = PH_INT;
        end else if (in_byte == CH_D) begin
          mode_nxt  = MODE_SCAN;
          phase_nxt = PH_IDLE;
        end else begin
          mode_nxt  = MODE_NONE;
          phase_nxt = PH_DONE;
        end
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
            if (is_digit) begin
              phase_nxt = PH_LEN;
              cnt_nxt   = {{(LEN_BITS-4){1'b0}}, dval};
              ovf_nxt   = 1'b0;
            end else if (in_byte == CH_I) begin
              phase_nxt = PH_INT;
            end
          end
          PH_LEN, PH_LENTAIL: begin
            if (is_digit && (phase_r == PH_LEN)) begin
              if (|len_v[LEN_BITS+3:LEN_BITS]) begin
                cnt_nxt = '1;
                ovf_nxt = 1'b1;
              end else begin
                cnt_nxt = len_v[LEN_BITS-1:0];
              end
            end else if (in_byte == CH_COLON) begin
              if (cnt_r == '0) begin
                res_v[n_v] = mk_res(EV_END, 8'h00, KIND_STR, end_st);
                n_v = n_v + 2'd1;
                phase_nxt = done_phase;
                cnt_nxt   = '0;
                ovf_nxt   = 1'b0;
              end else begin
                phase_nxt = PH_DATA;
              end
            end else if (phase_r == PH_LEN) begin
              phase_nxt = PH_LENTAIL;
            end
          end
          PH_DATA: begin
            res_v[n_v] = mk_res(EV_BYTE, in_byte, KIND_STR, ST_OK);
            n_v = n_v + 2'd1;
            if (cnt_dec == '0) begin
              res_v[n_v] = mk_res(EV_END, 8'h00, KIND_STR, end_st);
              n_v = n_v + 2'd1;
              phase_nxt = done_phase;
              cnt_nxt   = '0;
              ovf_nxt   = 1'b0;
            end else begin
              cnt_nxt = cnt_dec;
            end
          end
          PH_INT: begin
            if (in_byte == CH_E) begin
              res_v[n_v] = mk_res(EV_END, 8'h00, KIND_INT, ST_OK);
              n_v = n_v + 2'd1;
              phase_nxt = done_phase;
              cnt_nxt   = '0;
              ovf_nxt   = 1'b0;
            end else begin
              res_v[n_v] = mk_res(EV_BYTE, in_byte, KIND_INT, ST_OK);
              n_v = n_v + 2'd1;
            end
          end
          default: begin
          end
        endcase
      end

      if (in_final_byte) begin
        // close whatever token is still open, then mark end of input
        if ((phase_nxt == PH_LEN) || (phase_nxt == PH_LENTAIL)) begin
          res_v[n_v] = mk_res(EV_END, 8'h00, KIND_STR, ST_UNTERM);
          n_v = n_v + 2'd1;
        end else if (phase_nxt == PH_INT) begin
          res_v[n_v] = mk_res(EV_END, 8'h00, KIND_INT, ST_UNTERM);
          n_v = n_v + 2'd1;
        end else if (phase_nxt == PH_DATA) begin
          res_v[n_v] = mk_res(EV_END, 8'h00, KIND_STR, ovf_nxt ? ST_SAT : ST_TRUNC);
          n_v = n_v + 2'd1;
        end
        res_v[n_v] = mk_res(EV_EOI, 8'h00, KIND_STR, ST_OK);
        n_v = n_v + 2'd1;
        mode_nxt  = MODE_START;
        phase_nxt = PH_IDLE;
        cnt_nxt   = '0;
        seen_nxt  = '0;
        ovf_nxt   = 1'b0;
      end
    end
  end

  assign q_push       = accept && (n_v != '0);
  assign q_bundle.n   = n_v;
  assign q_bundle.res = res_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_START;
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      seen_r  <= '0;
      ovf_r   <= 1'b0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      seen_r  <= seen_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

>>> rtl/btsp_queue.sv
// Short bundle queue between the parser front end and the result back end.
module btsp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_push,
  input  btsp_pkg::bundle_t  q_wdata,
  input  logic               q_pop,
  output btsp_pkg::bundle_t  q_head,
  output logic               q_full,
  output logic               q_empty
);
  import btsp_pkg::*;

  bundle_t             slot_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]     count_r;
  logic                do_push, do_pop;

  assign q_full  = (count_r == (QPTR_W+1)'(QDEPTH));
  assign q_empty = (count_r == '0);
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && !q_empty;
  assign q_head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + (QPTR_W)'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + (QPTR_W)'(1);
      if (do_push && !do_pop)      count_r <= count_r + (QPTR_W+1)'(1);
      else if (do_pop && !do_push) count_r <= count_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= q_wdata;
  end

endmodule

>>> rtl/btsp_back.sv
// Back end: walks the head bundle and drives the result output register.
module btsp_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  btsp_pkg::bundle_t      q_head,
  input  logic                   q_empty,
  output logic                   q_pop,
  input  logic                   out_pop,
  output logic                   out_empty,
  output btsp_pkg::res_t         out_res,
  output logic                   out_run_last
);
  import btsp_pkg::*;

  logic                 out_valid_r;
  res_t                 out_res_r;
  logic                 run_last_r;
  logic [RIDX_W-1:0]    idx_r;
  logic                 load, is_last;

  assign load    = (!out_valid_r || out_pop) && !q_empty;
  assign is_last = (idx_r == (q_head.n - 2'd1));
  // release the bundle once its last result moves out
  assign q_pop   = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= 1'b1;
      idx_r       <= is_last ? '0 : idx_r + 2'd1;
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r  <= q_head.res[idx_r];
      run_last_r <= is_last;
    end
  end

  assign out_empty    = !out_valid_r;
  assign out_res      = out_res_r;
  assign out_run_last = run_last_r;

endmodule

>>> rtl/bencode_token_stream_parser_core.sv
// Top level of the bencode token stream parser.
//
//  channel | ports                                       | transfer when
//  --------+---------------------------------------------+----------------------
//  input   | in_byte, in_final_byte, in_push, in_full     | in_push & !in_full
//  result  | out_event_res, out_data, out_element_kind,  | out_pop & !out_empty
//          | out_status, out_run_last, out_empty, out_pop |
//
// One byte is taken per cycle while in_full is low. The output register moves one
// result per cycle while out_pop keeps it free; a byte's results pass through the
// queue and then the output register. The four-bundle queue between parser and output
// absorbs bursts; in_full rises when it is full. rst_n is synchronous and returns the
// parser to the start of a new input and empties the queue.
module bencode_token_stream_parser_core #(
  parameter int LEN_BITS = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_byte,
  input  logic       in_final_byte,
  input  logic       in_push,
  output logic       in_full,
  output logic [1:0] out_event_res,
  output logic [7:0] out_data,
  output logic       out_element_kind,
  output logic [1:0] out_status,
  output logic       out_run_last,
  output logic       out_empty,
  input  logic       out_pop
);
  import btsp_pkg::*;

  logic    accept;
  logic    q_push, q_pop, q_empty;
  bundle_t q_wdata, q_head;
  res_t    out_res;

  assign accept = in_push && !in_full;

  btsp_front #(.LEN_BITS(LEN_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .in_byte       (in_byte),
    .in_final_byte (in_final_byte),
    .q_push        (q_push),
    .q_bundle      (q_wdata)
  );

  btsp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_pop   (q_pop),
    .q_head  (q_head),
    .q_full  (in_full),
    .q_empty (q_empty)
  );

  btsp_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_head       (q_head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .out_res      (out_res),
    .out_run_last (out_run_last)
  );

  assign out_event_res    = out_res.ev;
  assign out_data         = out_res.data;
  assign out_element_kind = out_res.kind;
  assign out_status       = out_res.status;

  a_final_gives_eoi: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_final_byte |-> q_push && (q_wdata.res[q_wdata.n - 2'd1].ev == EV_EOI))
    else $error("final byte without end-of-input result");

  a_eoi_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && (out_event_res == EV_EOI) |-> out_run_last)
    else $error("end-of-input result not marked last");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("bundle released from empty queue");

  a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !in_full)
    else $error("bundle pushed into full queue");

endmodule
